FILE: design/didss_pkg.sv
// ----------------------------------------------------------------------------
// didss_pkg
// Shared types, codes and reset constants of the display idle sequencer.
// ----------------------------------------------------------------------------
package didss_pkg;

    localparam int unsigned MS_W    = 24;
    localparam int unsigned LEVEL_W = 8;
    localparam int unsigned CFG_IDX_W = 3;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_ART    = 2'd1,
        MODE_DIM    = 2'd2,
        MODE_SLEEP  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        STAGE_NONE  = 2'd0,
        STAGE_ART   = 2'd1,
        STAGE_DIM   = 2'd2,
        STAGE_SLEEP = 2'd3
    } stage_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ART_TIMEOUT   = 3'd0,
        REG_DIM_TIMEOUT   = 3'd1,
        REG_SLEEP_TIMEOUT = 3'd2,
        REG_LEVEL_NORMAL  = 3'd3,
        REG_LEVEL_DIM     = 3'd4,
        REG_RADIO_SAVE    = 3'd5,
        REG_CLOCK_SCALE   = 3'd6
    } cfg_reg_t;

    localparam logic [MS_W-1:0]    ART_TIMEOUT_RST   = 24'd30000;
    localparam logic [MS_W-1:0]    DIM_TIMEOUT_RST   = 24'd60000;
    localparam logic [MS_W-1:0]    SLEEP_TIMEOUT_RST = 24'd300000;
    localparam logic [LEVEL_W-1:0] LEVEL_NORMAL_RST  = 8'd255;
    localparam logic [LEVEL_W-1:0] LEVEL_DIM_RST     = 8'd64;

    // First enabled stage at or after 'from'; a zero timeout disables a stage.
    function automatic stage_t first_stage(
        input stage_t          from,
        input logic [MS_W-1:0] art_ms,
        input logic [MS_W-1:0] dim_ms,
        input logic [MS_W-1:0] sleep_ms
    );
        stage_t s;
        priority if (from <= STAGE_ART && art_ms != '0) begin
            s = STAGE_ART;
        end else if (from <= STAGE_DIM && dim_ms != '0) begin
            s = STAGE_DIM;
        end else if (sleep_ms != '0) begin
            s = STAGE_SLEEP;
        end else begin
            s = STAGE_NONE;
        end
        return s;
    endfunction

    // Timeout that belongs to a stage; nothing armed loads zero.
    function automatic logic [MS_W-1:0] stage_ms(
        input stage_t          stage,
        input logic [MS_W-1:0] art_ms,
        input logic [MS_W-1:0] dim_ms,
        input logic [MS_W-1:0] sleep_ms
    );
        logic [MS_W-1:0] v;
        unique case (stage)
            STAGE_ART:   v = art_ms;
            STAGE_DIM:   v = dim_ms;
            STAGE_SLEEP: v = sleep_ms;
            default:     v = '0;
        endcase
        return v;
    endfunction

endpackage

FILE: design/display_idle_dim_sleep_sequencer.sv
// ----------------------------------------------------------------------------
// display_idle_dim_sleep_sequencer
// Idle timeout sequencer for a display: normal, art, dim and sleep states.
// ----------------------------------------------------------------------------
// Input channel (s_*): one item per event, s_op = 0 for a one-millisecond
// tick, s_op = 1 for user activity; s_art_allowed gates entry to art mode.
// Result channel (m_*): one item per input item, showing mode, backlight
// duty, panel/controls state, power-save requests and the touch window
// after the event has been applied.
// Configuration (cfg_*): register index and data, always ready; write only
// while no item is in flight.
// The result is registered and is valid in the cycle after input accept.
// Throughput is one item per cycle while the receiver takes each result: the whole
// update is a single pass of logic between the state registers and the result register.
// A stalled receiver holds the result register; the input side keeps taking
// items in the same cycle the held result is taken, and stops otherwise.
// Reset returns configuration to its defaults, the mode to normal, closes
// the touch window and arms the first enabled stage with its timeout.
// ----------------------------------------------------------------------------
module display_idle_dim_sleep_sequencer #(
    parameter int unsigned TOUCH_SUPPRESS_MS = 250,
    parameter int unsigned TIMEOUT_BITS      = 24
) (
    input  logic                           aclk,
    input  logic                           aresetn,

    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_op,
    input  logic                           s_art_allowed,

    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [1:0]                     m_mode,
    output logic [didss_pkg::LEVEL_W-1:0]  m_backlight,
    output logic                           m_panel_on,
    output logic                           m_controls_shown,
    output logic                           m_radio_save,
    output logic                           m_clock_low,
    output logic                           m_touch_suppressed,

    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [didss_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [didss_pkg::MS_W-1:0]     cfg_data
);

    localparam logic [32:0] CNT_MAX = (33'd1 << TIMEOUT_BITS) - 33'd1;

    // Load value of the countdown, saturated to its width.
    function automatic logic [TIMEOUT_BITS-1:0] sat_ms(input logic [didss_pkg::MS_W-1:0] ms);
        logic [TIMEOUT_BITS-1:0] v;
        if (33'(ms) > CNT_MAX) begin
            v = CNT_MAX[TIMEOUT_BITS-1:0];
        end else begin
            v = TIMEOUT_BITS'(ms);
        end
        return v;
    endfunction

    // configuration
    logic [didss_pkg::MS_W-1:0]    art_ms_reg, dim_ms_reg, sleep_ms_reg;
    logic [didss_pkg::LEVEL_W-1:0] level_normal_reg, level_dim_reg;
    logic                          radio_en_reg, clock_en_reg;

    // state
    didss_pkg::mode_t        mode_reg, mode_next;
    didss_pkg::stage_t       stage_reg, stage_next;
    logic [TIMEOUT_BITS-1:0] cnt_reg, cnt_next;
    logic [7:0]              win_reg, win_next;

    // result register
    logic                          m_valid_reg;
    logic [1:0]                    m_mode_reg;
    logic [didss_pkg::LEVEL_W-1:0] m_backlight_reg;
    logic                          m_panel_on_reg, m_controls_reg;
    logic                          m_radio_reg, m_clock_reg, m_touch_reg;

    logic                          in_fire;
    logic                          sleeping;
    didss_pkg::stage_t             arm_stage;

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign in_fire   = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            art_ms_reg       <= didss_pkg::ART_TIMEOUT_RST;
            dim_ms_reg       <= didss_pkg::DIM_TIMEOUT_RST;
            sleep_ms_reg     <= didss_pkg::SLEEP_TIMEOUT_RST;
            level_normal_reg <= didss_pkg::LEVEL_NORMAL_RST;
            level_dim_reg    <= didss_pkg::LEVEL_DIM_RST;
            radio_en_reg     <= 1'b0;
            clock_en_reg     <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                didss_pkg::REG_ART_TIMEOUT:   art_ms_reg       <= cfg_data;
                didss_pkg::REG_DIM_TIMEOUT:   dim_ms_reg       <= cfg_data;
                didss_pkg::REG_SLEEP_TIMEOUT: sleep_ms_reg     <= cfg_data;
                didss_pkg::REG_LEVEL_NORMAL:  level_normal_reg <= cfg_data[didss_pkg::LEVEL_W-1:0];
                didss_pkg::REG_LEVEL_DIM:     level_dim_reg    <= cfg_data[didss_pkg::LEVEL_W-1:0];
                didss_pkg::REG_RADIO_SAVE:    radio_en_reg     <= cfg_data[0];
                didss_pkg::REG_CLOCK_SCALE:   clock_en_reg     <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Event update: tick counts down and fires, activity wakes and re-arms.
    always_comb begin
        mode_next  = mode_reg;
        stage_next = stage_reg;
        cnt_next   = cnt_reg;
        win_next   = win_reg;
        arm_stage  = didss_pkg::STAGE_NONE;
        if (!s_op) begin
            if (win_reg != '0) begin
                win_next = win_reg - 8'd1;
            end
            if (stage_reg != didss_pkg::STAGE_NONE) begin
                if (cnt_reg > TIMEOUT_BITS'(1)) begin
                    cnt_next = cnt_reg - TIMEOUT_BITS'(1);
                end else begin
                    stage_next = didss_pkg::STAGE_NONE;
                    cnt_next   = '0;
                    unique case (stage_reg)
                        didss_pkg::STAGE_ART: begin
                            if (s_art_allowed && mode_reg == didss_pkg::MODE_NORMAL) begin
                                mode_next = didss_pkg::MODE_ART;
                            end
                            arm_stage  = didss_pkg::first_stage(didss_pkg::STAGE_DIM,
                                             art_ms_reg, dim_ms_reg, sleep_ms_reg);
                            stage_next = arm_stage;
                            cnt_next   = sat_ms(didss_pkg::stage_ms(arm_stage,
                                             art_ms_reg, dim_ms_reg, sleep_ms_reg));
                        end
                        didss_pkg::STAGE_DIM: begin
                            if (mode_reg == didss_pkg::MODE_NORMAL ||
                                mode_reg == didss_pkg::MODE_ART) begin
                                mode_next  = didss_pkg::MODE_DIM;
                                arm_stage  = didss_pkg::first_stage(didss_pkg::STAGE_SLEEP,
                                                 art_ms_reg, dim_ms_reg, sleep_ms_reg);
                                stage_next = arm_stage;
                                cnt_next   = sat_ms(didss_pkg::stage_ms(arm_stage,
                                                 art_ms_reg, dim_ms_reg, sleep_ms_reg));
                            end
                        end
                        default: begin
                            mode_next = didss_pkg::MODE_SLEEP;
                        end
                    endcase
                end
            end
        end else begin
            if (mode_reg != didss_pkg::MODE_NORMAL) begin
                mode_next = didss_pkg::MODE_NORMAL;
                win_next  = 8'(TOUCH_SUPPRESS_MS);
            end
            arm_stage  = didss_pkg::first_stage(didss_pkg::STAGE_ART,
                             art_ms_reg, dim_ms_reg, sleep_ms_reg);
            stage_next = arm_stage;
            cnt_next   = sat_ms(didss_pkg::stage_ms(arm_stage,
                             art_ms_reg, dim_ms_reg, sleep_ms_reg));
        end
    end

    assign sleeping = (mode_next == didss_pkg::MODE_SLEEP);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= didss_pkg::MODE_NORMAL;
            stage_reg <= didss_pkg::STAGE_ART;
            cnt_reg   <= sat_ms(didss_pkg::ART_TIMEOUT_RST);
            win_reg   <= '0;
        end else if (in_fire) begin
            mode_reg  <= mode_next;
            stage_reg <= stage_next;
            cnt_reg   <= cnt_next;
            win_reg   <= win_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (in_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            m_mode_reg <= mode_next;
            if (mode_next == didss_pkg::MODE_DIM) begin
                m_backlight_reg <= level_dim_reg;
            end else if (sleeping) begin
                m_backlight_reg <= '0;
            end else begin
                m_backlight_reg <= level_normal_reg;
            end
            m_panel_on_reg <= !sleeping;
            m_controls_reg <= (mode_next == didss_pkg::MODE_NORMAL);
            m_radio_reg    <= sleeping && radio_en_reg;
            m_clock_reg    <= sleeping && clock_en_reg;
            m_touch_reg    <= (win_next != '0);
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_mode             = m_mode_reg;
    assign m_backlight        = m_backlight_reg;
    assign m_panel_on         = m_panel_on_reg;
    assign m_controls_shown   = m_controls_reg;
    assign m_radio_save       = m_radio_reg;
    assign m_clock_low        = m_clock_reg;
    assign m_touch_suppressed = m_touch_reg;

endmodule

FILE: design/didss_checker.sv
// ----------------------------------------------------------------------------
// didss_checker
// Port-level checks of the display idle sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module didss_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_valid,
    input logic                            s_ready,
    input logic                            s_op,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic [1:0]                      m_mode,
    input logic [didss_pkg::LEVEL_W-1:0]   m_backlight,
    input logic                            m_panel_on,
    input logic                            m_controls_shown
);

    // Drop any result on reset.
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_mode) && $stable(m_backlight))
        else $error("stalled result changed");

    a_activity_wakes: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_op |=> m_valid && m_mode == didss_pkg::MODE_NORMAL)
        else $error("activity did not wake to normal");

    a_sleep_dark: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_mode == didss_pkg::MODE_SLEEP |-> !m_panel_on && m_backlight == '0)
        else $error("panel lit while sleeping");

    a_controls: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_controls_shown == (m_mode == didss_pkg::MODE_NORMAL))
        else $error("controls state disagrees with mode");

endmodule

bind display_idle_dim_sleep_sequencer didss_checker u_didss_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_valid          (s_valid),
    .s_ready          (s_ready),
    .s_op             (s_op),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_mode           (m_mode),
    .m_backlight      (m_backlight),
    .m_panel_on       (m_panel_on),
    .m_controls_shown (m_controls_shown)
);
